### hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the sorted priority queue.
// No dependencies; every other file refers to it by scoped names.
package spq_pkg;

  localparam int CAPACITY    = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ITEM_DATA_W = 32;
  localparam int PRIO_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [DATA_WIDTH-1:0]    data;
    logic signed [PRIO_W-1:0] prio;
  } spq_entry_t;

  // Broadcast to every cell for one request
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t fresh;
  } spq_ctrl_t;

endpackage

### hw/rtl/spq_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the queue.
// Depends on spq_pkg for field widths.
interface spq_req_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     action;
  logic [spq_pkg::ITEM_DATA_W-1:0]          item_data;
  logic signed [spq_pkg::PRIO_W-1:0]        item_priority;

  modport source(output valid, action, item_data, item_priority, input ready);
  modport sink(input valid, action, item_data, item_priority, output ready);
endinterface

interface spq_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic [spq_pkg::ITEM_DATA_W-1:0]          head_data;
  logic signed [spq_pkg::PRIO_W-1:0]        head_priority;
  logic                                     head_valid;
  logic [spq_pkg::STATUS_W-1:0]             status;
  logic [spq_pkg::OCC_W-1:0]                occupancy;

  modport source(output valid, head_data, head_priority, head_valid, status, occupancy,
                 input ready);
  modport sink(input valid, head_data, head_priority, head_valid, status, occupancy,
               output ready);
endinterface

### hw/rtl/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry and trades with its neighbours.
// Depends on spq_pkg.
module spq_cell (
  input  logic                clk,
  input  spq_pkg::spq_ctrl_t  ctrl,
  input  logic                occupied,
  input  logic                prev_le,
  input  spq_pkg::spq_entry_t prev_entry,
  input  spq_pkg::spq_entry_t next_entry,
  output spq_pkg::spq_entry_t entry,
  output logic                le
);

  // Held entry stays ahead of the new one (ties keep first-in order)
  assign le = occupied && ($signed(entry.prio) <= $signed(ctrl.fresh.prio));

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!le) begin
        entry <= prev_le ? ctrl.fresh : prev_entry;
      end
    end else if (ctrl.rem) begin
      entry <= next_entry;
    end
  end

endmodule

### hw/rtl/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// Sorted priority queue top level: request/result channels, count, cell row.
// Depends on spq_pkg, spq_ifs and spq_cell.

// The queue holds up to CAPACITY entries in a row of cells kept in ascending
// priority order, cell 0 being the head. Every request (insert or remove) is
// handled in a single step: all cells compare against the new priority at once and
// either keep, take the new entry, or shift one place, so a request is
// finished in the cycle it is accepted and its result sits in the output
// register from the next cycle. Throughput is one request per cycle while the
// result side keeps ready high; apart from reset, the only thing that holds off a
// request is an untaken result in the output register. Ties leave in arrival
// order. An insert into a full queue is dropped with status full; a remove
// from an empty queue returns status empty. Data and priority of the result
// are zero unless an entry was removed.
module sorted_priority_queue_top (
  input logic     clk,
  input logic     rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;
  logic                      full;
  logic                      empty;
  logic                      accept;
  spq_pkg::spq_ctrl_t        ctrl;

  spq_pkg::spq_entry_t cell_entry [spq_pkg::CAPACITY];
  logic                cell_le    [spq_pkg::CAPACITY];

  // Output register
  logic                              rsp_valid;
  logic [spq_pkg::ITEM_DATA_W-1:0]   rsp_head_data;
  logic signed [spq_pkg::PRIO_W-1:0] rsp_head_priority;
  logic                              rsp_head_valid;
  logic [spq_pkg::STATUS_W-1:0]      rsp_status;
  logic [spq_pkg::OCC_W-1:0]         rsp_occupancy;

  assign full   = (count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign empty  = (count == '0);
  // No request is taken while in reset
  assign req.ready = !rst && (!rsp_valid || rsp.ready);
  assign accept = req.valid && req.ready;

  assign ctrl.ins = accept && (req.action == spq_pkg::ACT_INSERT) && !full;
  assign ctrl.rem = accept && (req.action == spq_pkg::ACT_REMOVE) && !empty;
  assign ctrl.fresh.data = spq_pkg::DATA_WIDTH'(req.item_data);
  assign ctrl.fresh.prio = req.item_priority;

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.rem) begin
      count_next = count - 1'b1;
    end
  end

  // Cell row: cell 0 sees an always-true left neighbour, the tail cell
  // refills from itself on a remove (its slot falls out of the count).
  for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
    logic                prev_le;
    spq_pkg::spq_entry_t prev_entry;
    spq_pkg::spq_entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev_le    = 1'b1;
      assign prev_entry = ctrl.fresh;
    end else begin : g_mid
      assign prev_le    = cell_le[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == spq_pkg::CAPACITY - 1) begin : g_last
      assign next_entry = cell_entry[i];
    end else begin : g_notlast
      assign next_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (spq_pkg::CNT_W'(i) < count),
      .prev_le    (prev_le),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (cell_entry[i]),
      .le         (cell_le[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_head_data     <= ctrl.rem ? spq_pkg::ITEM_DATA_W'(cell_entry[0].data) : '0;
      rsp_head_priority <= ctrl.rem ? cell_entry[0].prio : '0;
      rsp_head_valid    <= ctrl.rem;
      rsp_occupancy     <= spq_pkg::OCC_W'(count_next);
      if ((req.action == spq_pkg::ACT_INSERT) && full) begin
        rsp_status <= spq_pkg::ST_FULL;
      end else if ((req.action == spq_pkg::ACT_REMOVE) && empty) begin
        rsp_status <= spq_pkg::ST_EMPTY;
      end else begin
        rsp_status <= spq_pkg::ST_DONE;
      end
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.head_data     = rsp_head_data;
  assign rsp.head_priority = rsp_head_priority;
  assign rsp.head_valid    = rsp_head_valid;
  assign rsp.status        = rsp_status;
  assign rsp.occupancy     = rsp_occupancy;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the count");

  a_head_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.head_valid) |-> rsp.status == spq_pkg::ST_DONE)
    else $error("returned head with error status");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= spq_pkg::CNT_W'(2)) |->
      ($signed(cell_entry[0].prio) <= $signed(cell_entry[1].prio)))
    else $error("head cells out of order");

endmodule
